[rtl/bhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bhs_pkg;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// sample fetch request leaving the address stages
	typedef struct packed {
		logic        query;
		logic [11:0] waddr;
		logic [23:0] row0;
		logic [23:0] row1;
		logic [11:0] x0;
		logic [11:0] x1;
	} smp_req_t;

	typedef struct packed {
		logic [15:0] tx;
		logic [15:0] ty;
	} wgt_t;

	// negative goes to zero, anything past 1.0 goes to 1.0
	function automatic logic [16:0] coord_clamp(input logic [17:0] c);
		logic [16:0] r;
		if (c[17]) begin
			r = 17'd0;
		end else if (c[16:0] > ONE_Q16) begin
			r = ONE_Q16;
		end else begin
			r = c[16:0];
		end
		return r;
	endfunction

	function automatic logic [12:0] dim_clamp(input logic [12:0] d);
		logic [12:0] r;
		if (d == 13'd0) begin
			r = 13'd1;
		end else if (d[12] && (d[11:0] != 12'd0)) begin
			r = 13'd4096;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/bilinear_height_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------------
// request   | start / busy          | op, write_address, write_value, u_coord,
//           |                       | v_coord
// result    | result_valid (strobe) | height_out
// config    | cfg_we                | cfg_index, cfg_wdata
//
// one request is taken every cycle; busy is always low
// a query result passes through the register stages before it reaches the ports;
// writes give none
// there are six register stages: clamp, scale, row offset,
// store read, row blend, column blend and round
// reset clears the pipeline valid bits and sets both grid sizes to 1; the store is not cleared
// results are strobed for one cycle and cannot be held off
module bilinear_height_sampler import bhs_pkg::*; #(
	parameter int CAPACITY    = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               op,
	input  wire logic [11:0]        write_address,
	input  wire logic [15:0]        write_value,
	input  wire logic signed [17:0] u_coord,
	input  wire logic signed [17:0] v_coord,
	output logic                    result_valid,
	output logic [15:0]             height_out,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [12:0]        cfg_wdata
);

	logic [12:0] grid_w_q, grid_h_q;

	logic                   req_valid;
	smp_req_t               req;
	logic [SAMPLE_BITS-1:0] req_wval;
	wgt_t                   req_wgt;

	logic                   smp_valid;
	logic [SAMPLE_BITS-1:0] smp_a, smp_b, smp_c, smp_d;
	wgt_t                   smp_wgt;

	assign busy = 1'b0;

	// sizes are stored already clamped to 1..4096
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= 13'd1;
			grid_h_q <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_w_q <= dim_clamp(cfg_wdata);
				REG_GRID_HEIGHT: grid_h_q <= dim_clamp(cfg_wdata);
				default: ;
			endcase
		end
	end

	bhs_addr_gen #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_addr_gen (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.op           (op),
		.write_address(write_address),
		.write_value  (write_value),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.grid_w       (grid_w_q),
		.grid_h       (grid_h_q),
		.req_valid    (req_valid),
		.req          (req),
		.req_wval     (req_wval),
		.req_wgt      (req_wgt)
	);

	bhs_store #(
		.CAPACITY   (CAPACITY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_wval (req_wval),
		.req_wgt  (req_wgt),
		.smp_valid(smp_valid),
		.smp_a    (smp_a),
		.smp_b    (smp_b),
		.smp_c    (smp_c),
		.smp_d    (smp_d),
		.smp_wgt  (smp_wgt)
	);

	bhs_blend #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_a     (smp_a),
		.smp_b     (smp_b),
		.smp_c     (smp_c),
		.smp_d     (smp_d),
		.smp_wgt   (smp_wgt),
		.out_valid (result_valid),
		.out_height(height_out)
	);

endmodule
`default_nettype wire

[rtl/bhs_addr_gen.sv]
`timescale 1ns / 1ps
`default_nettype none
module bhs_addr_gen import bhs_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   op,
	input  wire logic [11:0]            write_address,
	input  wire logic [15:0]            write_value,
	input  wire logic signed [17:0]     u_coord,
	input  wire logic signed [17:0]     v_coord,
	input  wire logic [12:0]            grid_w,
	input  wire logic [12:0]            grid_h,
	output logic                        req_valid,
	output smp_req_t                    req,
	output logic [SAMPLE_BITS-1:0]      req_wval,
	output wgt_t                        req_wgt
);

	logic [11:0] wm1, hm1;
	logic [SAMPLE_BITS-1:0] wval_in;

	logic                   valid_s1, op_s1;
	logic [11:0]            waddr_s1;
	logic [SAMPLE_BITS-1:0] wval_s1;
	logic [16:0]            cu_s1, cv_s1;

	logic                   valid_s2, op_s2;
	logic [11:0]            waddr_s2;
	logic [SAMPLE_BITS-1:0] wval_s2;
	logic [27:0]            fx_s2, fy_s2;

	logic [11:0] x0, y0, x1, y1;

	logic                   valid_s3;
	smp_req_t               req_s3;
	logic [SAMPLE_BITS-1:0] wval_s3;
	wgt_t                   wgt_s3;

	assign wm1 = 12'(grid_w - 13'd1);
	assign hm1 = 12'(grid_h - 13'd1);

	always_comb begin
		wval_in = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (i < 16) begin
				wval_in[i] = write_value[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= op;
		waddr_s1 <= write_address;
		wval_s1  <= wval_in;
		cu_s1    <= coord_clamp(u_coord);
		cv_s1    <= coord_clamp(v_coord);
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		waddr_s2 <= waddr_s1;
		wval_s2  <= wval_s1;
		fx_s2    <= {11'd0, cu_s1} * {16'd0, wm1};
		fy_s2    <= {11'd0, cv_s1} * {16'd0, hm1};
	end

	// far neighbour stops at the last column or row
	assign x0 = fx_s2[27:16];
	assign y0 = fy_s2[27:16];
	assign x1 = (x0 == wm1) ? wm1 : 12'(x0 + 12'd1);
	assign y1 = (y0 == hm1) ? hm1 : 12'(y0 + 12'd1);

	always_ff @(posedge clk) begin
		req_s3.query <= (op_s2 == OP_QUERY);
		req_s3.waddr <= waddr_s2;
		req_s3.row0  <= 24'({13'd0, y0} * {12'd0, grid_w});
		req_s3.row1  <= 24'({13'd0, y1} * {12'd0, grid_w});
		req_s3.x0    <= x0;
		req_s3.x1    <= x1;
		wval_s3      <= wval_s2;
		wgt_s3.tx    <= fx_s2[15:0];
		wgt_s3.ty    <= fy_s2[15:0];
	end

	assign req_valid = valid_s3;
	assign req       = req_s3;
	assign req_wval  = wval_s3;
	assign req_wgt   = wgt_s3;

endmodule
`default_nettype wire

[rtl/bhs_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module bhs_store import bhs_pkg::*; #(
	parameter int CAPACITY    = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	input  wire smp_req_t               req,
	input  wire logic [SAMPLE_BITS-1:0] req_wval,
	input  wire wgt_t                   req_wgt,
	output logic                        smp_valid,
	output logic [SAMPLE_BITS-1:0]      smp_a,
	output logic [SAMPLE_BITS-1:0]      smp_b,
	output logic [SAMPLE_BITS-1:0]      smp_c,
	output logic [SAMPLE_BITS-1:0]      smp_d,
	output wgt_t                        smp_wgt
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [24:0] CAP = 25'(CAPACITY);

	// two copies, each with two read ports: top row pair and bottom row pair
	logic [SAMPLE_BITS-1:0] mem_top [CAPACITY];
	logic [SAMPLE_BITS-1:0] mem_bot [CAPACITY];

	logic [24:0] idx_a, idx_b, idx_c, idx_d, idx_w;
	logic        wr_en;

	logic                   valid_s4;
	logic                   ok_a_s4, ok_b_s4, ok_c_s4, ok_d_s4;
	logic [SAMPLE_BITS-1:0] a_s4, b_s4, c_s4, d_s4;
	wgt_t                   wgt_s4;

	assign idx_a = {1'b0, req.row0} + {13'd0, req.x0};
	assign idx_b = {1'b0, req.row0} + {13'd0, req.x1};
	assign idx_c = {1'b0, req.row1} + {13'd0, req.x0};
	assign idx_d = {1'b0, req.row1} + {13'd0, req.x1};
	assign idx_w = {13'd0, req.waddr};
	assign wr_en = req_valid && !req.query && (idx_w < CAP);

	// writes land at the same stage as reads, so request order is kept
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_top[idx_w[AW-1:0]] <= req_wval;
			mem_bot[idx_w[AW-1:0]] <= req_wval;
		end
		a_s4 <= mem_top[idx_a[AW-1:0]];
		b_s4 <= mem_top[idx_b[AW-1:0]];
		c_s4 <= mem_bot[idx_c[AW-1:0]];
		d_s4 <= mem_bot[idx_d[AW-1:0]];
		ok_a_s4 <= idx_a < CAP;
		ok_b_s4 <= idx_b < CAP;
		ok_c_s4 <= idx_c < CAP;
		ok_d_s4 <= idx_d < CAP;
		wgt_s4  <= req_wgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= req_valid && req.query;
		end
	end

	// past the end of the store reads as zero
	assign smp_valid = valid_s4;
	assign smp_a     = ok_a_s4 ? a_s4 : '0;
	assign smp_b     = ok_b_s4 ? b_s4 : '0;
	assign smp_c     = ok_c_s4 ? c_s4 : '0;
	assign smp_d     = ok_d_s4 ? d_s4 : '0;
	assign smp_wgt   = wgt_s4;

endmodule
`default_nettype wire

[rtl/bhs_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
module bhs_blend import bhs_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   smp_valid,
	input  wire logic [SAMPLE_BITS-1:0] smp_a,
	input  wire logic [SAMPLE_BITS-1:0] smp_b,
	input  wire logic [SAMPLE_BITS-1:0] smp_c,
	input  wire logic [SAMPLE_BITS-1:0] smp_d,
	input  wire wgt_t                   smp_wgt,
	output logic                        out_valid,
	output logic [15:0]                 out_height
);

	localparam int TW = SAMPLE_BITS + 17;
	localparam int SW = SAMPLE_BITS + 34;

	logic [TW-1:0] wx1, wx0;
	logic [SW-1:0] wy1, wy0;

	logic          valid_s5;
	logic [TW-1:0] top_s5, bot_s5;
	logic [15:0]   ty_s5;

	logic          valid_s6;
	logic [SW-1:0] sum_s6;
	logic [SW-1:0] rnd;

	assign wx1 = TW'(smp_wgt.tx);
	assign wx0 = TW'(ONE_Q16) - wx1;

	always_ff @(posedge clk) begin
		top_s5 <= TW'(smp_a) * wx0 + TW'(smp_b) * wx1;
		bot_s5 <= TW'(smp_c) * wx0 + TW'(smp_d) * wx1;
		ty_s5  <= smp_wgt.ty;
	end

	assign wy1 = SW'(ty_s5);
	assign wy0 = SW'(ONE_Q16) - wy1;

	always_ff @(posedge clk) begin
		sum_s6 <= SW'(top_s5) * wy0 + SW'(bot_s5) * wy1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= smp_valid;
			valid_s6 <= valid_s5;
		end
	end

	// round half up at the 32-bit fraction point
	assign rnd = sum_s6 + (SW'(1) << 31);

	always_comb begin
		out_height = '0;
		for (int i = 0; i < 16; i++) begin
			if (i < SAMPLE_BITS) begin
				out_height[i] = rnd[32 + i];
			end
		end
	end

	assign out_valid = valid_s6;

endmodule
`default_nettype wire

[tb/sv/tb_bilinear_height_sampler.sv]
`timescale 1ns / 1ps
module tb_bilinear_height_sampler;
	import bhs_pkg::*;

	localparam int STORE_DEPTH = 4096;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT = 4000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               op;
	logic [11:0]        write_address;
	logic [15:0]        write_value;
	logic signed [17:0] u_coord;
	logic signed [17:0] v_coord;
	logic               result_valid;
	logic [15:0]        height_out;
	logic               cfg_we;
	logic               cfg_index;
	logic [12:0]        cfg_wdata;

	bilinear_height_sampler u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.write_address(write_address), .write_value(write_value),
		.u_coord(u_coord), .v_coord(v_coord), .result_valid(result_valid),
		.height_out(height_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [15:0] sample_mem [STORE_DEPTH];
	bit          sample_known [STORE_DEPTH];
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	logic [15:0] heights_due [$];

	int errors;
	int n_queries;
	int n_writes;
	int n_results;
	int idle_pct;
	int stall_cycles;

	typedef struct {
		logic [12:0] w;
		logic [12:0] h;
		logic        qop;
		logic [11:0] addr;
		logic [15:0] val;
		logic [17:0] u;
		logic [17:0] v;
		bit          fixed;
		logic [15:0] height;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{1, 1, OP_WRITE, 0, 16'hFFFF, 0, 0, 0, 0},
		'{1, 1, OP_QUERY, 0, 0, 0, 0, 1, 16'hFFFF},
		'{1, 1, OP_QUERY, 0, 0, 18'h20000, 18'h20000, 1, 16'hFFFF},
		'{1, 1, OP_QUERY, 0, 0, 18'h1FFFF, 18'h1FFFF, 1, 16'hFFFF},
		'{1, 1, OP_WRITE, 12'hFFF, 16'hFFFF, 0, 0, 0, 0},
		'{1, 1, OP_WRITE, 0, 0, 0, 0, 0, 0},
		'{1, 1, OP_QUERY, 0, 0, 18'h10000, 18'h0FFFF, 1, 16'h0000},
		'{1, 1, OP_WRITE, 0, 16'h8001, 0, 0, 0, 0},
		'{1, 1, OP_QUERY, 0, 0, 18'h00001, 18'h00001, 1, 16'h8001},
		'{1, 1, OP_WRITE, 12'hFFF, 16'h0000, 0, 0, 0, 0},
		'{2, 2, OP_WRITE, 0, 16'h0000, 0, 0, 0, 0},
		'{2, 2, OP_WRITE, 1, 16'hFFFF, 0, 0, 0, 0},
		'{2, 2, OP_WRITE, 2, 16'h1234, 0, 0, 0, 0},
		'{2, 2, OP_WRITE, 3, 16'hABCD, 0, 0, 0, 0},
		'{2, 2, OP_QUERY, 0, 0, 18'h08000, 18'h08000, 0, 0},
		'{2, 2, OP_QUERY, 0, 0, 18'h10000, 18'h00000, 1, 16'hFFFF},
		'{2, 2, OP_QUERY, 0, 0, 18'h00000, 18'h10000, 1, 16'h1234},
		'{2, 2, OP_QUERY, 0, 0, 18'h0FFFF, 18'h00001, 0, 0},
		'{2, 2, OP_QUERY, 0, 0, 18'h00001, 18'h0FFFF, 0, 0},
		'{0, 0, OP_QUERY, 0, 0, 18'h08000, 18'h08000, 1, 16'h0000},
		'{8191, 8191, OP_QUERY, 0, 0, 18'h00000, 18'h00000, 1, 16'h0000},
		'{8191, 8191, OP_QUERY, 0, 0, 18'h00000, 18'h10000, 0, 0}
	};

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned eff_dim(input logic [12:0] d);
		if (d == 0) return 1;
		if (d > 13'd4096) return 4096;
		return 32'(d);
	endfunction

	function automatic longint unsigned coord_q16(input logic [17:0] c);
		if (c[17]) return 0;
		if (c[16:0] > 17'd65536) return 65536;
		return 64'(c[16:0]);
	endfunction

	// the four linear indexes a query touches: top-left, top-right, bottom-left, bottom-right
	function automatic void corner_indexes(input logic [17:0] u, input logic [17:0] v,
			output longint unsigned idx[4], output longint unsigned tx,
			output longint unsigned ty);
		longint unsigned w, h, fx, fy, x0, y0, x1, y1;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		fx = coord_q16(u) * (w - 1);
		fy = coord_q16(v) * (h - 1);
		x0 = fx >> 16;
		y0 = fy >> 16;
		tx = fx & 16'hFFFF;
		ty = fy & 16'hFFFF;
		x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
		y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
		idx[0] = y0 * w + x0;
		idx[1] = y0 * w + x1;
		idx[2] = y1 * w + x0;
		idx[3] = y1 * w + x1;
	endfunction

	function automatic logic [15:0] blended_height(input logic [17:0] u, input logic [17:0] v);
		longint unsigned idx[4];
		longint unsigned s[4];
		longint unsigned tx, ty, top, bot, sum;
		corner_indexes(u, v, idx, tx, ty);
		for (int i = 0; i < 4; i++) begin
			s[i] = (idx[i] < STORE_DEPTH) ? longint'(sample_mem[idx[i]]) : 0;
		end
		top = s[0] * (65536 - tx) + s[1] * tx;
		bot = s[2] * (65536 - tx) + s[3] * tx;
		sum = top * (65536 - ty) + bot * ty;
		return 16'((sum + 64'h8000_0000) >> 32);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		errors++;
		$display("[%0t] mismatch %s: expected %h, got %h", $time, what, want, got);
	endtask

	// one request, after random idle cycles with start low, driven until taken
	task automatic issue(input logic qop, input logic [11:0] addr, input logic [15:0] val,
			input logic [17:0] u, input logic [17:0] v, input bit fixed,
			input logic [15:0] height);
		bit taken;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start = 1'b0;
				@(posedge clk);
			end else begin
				start = 1'b1;
				op = qop;
				write_address = addr;
				write_value = val;
				u_coord = u;
				v_coord = v;
				@(posedge clk);
				taken = !busy;
			end
		end
		if (qop == OP_WRITE) begin
			sample_mem[addr] = val;
			sample_known[addr] = 1;
			n_writes++;
		end else begin
			heights_due = {heights_due, fixed ? height : blended_height(u, v)};
			n_queries++;
		end
	endtask

	// write any never-written corner first so every read hits a defined entry
	task automatic query(input logic [17:0] u, input logic [17:0] v, input bit fixed,
			input logic [15:0] height);
		longint unsigned idx[4];
		longint unsigned tx, ty;
		corner_indexes(u, v, idx, tx, ty);
		for (int i = 0; i < 4; i++) begin
			if (idx[i] < STORE_DEPTH && !sample_known[idx[i]]) begin
				issue(OP_WRITE, 12'(idx[i]), 16'($urandom), '0, '0, 1'b0, '0);
			end
		end
		issue(OP_QUERY, 12'($urandom), 16'($urandom), u, v, fixed, height);
	endtask

	task automatic set_grid(input logic [12:0] w, input logic [12:0] h);
		@(negedge clk);
		start = 1'b0;
		while (heights_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_GRID_WIDTH;
		cfg_wdata = w;
		@(negedge clk);
		cfg_index = REG_GRID_HEIGHT;
		cfg_wdata = h;
		@(negedge clk);
		cfg_we = 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	function automatic logic [17:0] rand_coord();
		int k;
		k = $urandom_range(9);
		if (k < 6) return 18'($urandom_range(65536));
		if (k == 6) return 18'h10000;
		if (k == 7) return 18'h00000;
		return 18'($urandom);
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			n_results++;
			if (heights_due.size() == 0) begin
				report_mismatch("unexpected result", 16'h0, height_out);
			end else begin
				logic [15:0] want;
				want = heights_due.pop_front();
				if (height_out !== want) report_mismatch("height_out", want, height_out);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [12:0] grid_list [][2] = '{
			'{13'd3, 13'd7}, '{13'd0, 13'd5}, '{13'd4096, 13'd1}, '{13'd1, 13'd4096},
			'{13'd64, 13'd64}, '{13'd8191, 13'd0}, '{13'd4096, 13'd4096},
			'{13'd17, 13'd9}, '{13'd2, 13'd2}
		};
		int per_grid;
		int done;
		int total;
		int base;
		errors = 0;
		n_queries = 0;
		n_writes = 0;
		n_results = 0;
		stall_cycles = 0;
		idle_pct = 14;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_WRITE;
		write_address = '0;
		write_value = '0;
		u_coord = '0;
		v_coord = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_wdata = '0;
		width_reg = 1;
		height_reg = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].w != width_reg || dir_rows[i].h != height_reg)
				set_grid(dir_rows[i].w, dir_rows[i].h);
			if (dir_rows[i].qop == OP_WRITE)
				issue(OP_WRITE, dir_rows[i].addr, dir_rows[i].val, '0, '0, 1'b0, '0);
			else
				query(dir_rows[i].u, dir_rows[i].v, dir_rows[i].fixed, dir_rows[i].height);
		end

		// each grid adds requests until the running total reaches per_grid for every grid so far, corner writes included
		per_grid = 125;
		total = per_grid * grid_list.size();
		base = n_writes + n_queries;
		foreach (grid_list[g]) begin
			set_grid(grid_list[g][0], grid_list[g][1]);
			while (n_writes + n_queries < base + per_grid * (g + 1)) begin
				done = n_writes + n_queries - base;
				idle_pct = (done < total / 3) ? 14 : (done < 2 * total / 3) ? 51 : 0;
				if ($urandom_range(9) < 3) begin
					// bias writes into the active part of the grid
					issue(OP_WRITE, ($urandom_range(1)) ? 12'($urandom) :
						12'($urandom_range(eff_dim(width_reg) * eff_dim(height_reg) - 1)),
						16'($urandom), 18'($urandom), 18'($urandom), 1'b0, '0);
				end else begin
					query(rand_coord(), rand_coord(), 1'b0, '0);
				end
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (heights_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d sample writes and %0d queries over %0d grid sizes",
			n_writes, n_queries, grid_list.size() + 4);
		$display("%0d results checked, %0d mismatches", n_results, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
